### rtl/assert_macros.svh
// Assertion macros shared by the broadcast ring buffer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent holds in a cycle, consequent must hold in the same cycle.
`define BRB_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent holds in a cycle, consequent must hold in the following cycle.
`define BRB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/brb_pkg.sv
// Package with the types and fixed codes of the broadcast ring buffer.
`default_nettype none

package brb_pkg;

  // Fixed field widths of the stream payloads.
  localparam int unsigned RID_W       = 2;
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned SLOT_W      = 4;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 40;

  // Request kinds carried on in_tuser.
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  // Result status carried on out_tuser.
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } brb_state_t;

endpackage

`default_nettype wire

### rtl/brb_ram.sv
// Simple dual-port synchronous RAM with a registered read port.
`default_nettype none

module brb_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds while re is low, so a stalled consumer keeps its word.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/broadcast_ring_buffer_unit.sv
// Top level of the broadcast ring buffer: one writer, several readers, one shared ring.
//
// The block is a ring of DEPTH words with one writer and READERS readers, where every
// reader sees every written word exactly once and in order. Each request on the input
// stream is either a write (in_tuser low) or a read by one reader (in_tuser high) and
// yields exactly one result on the output stream. A write is refused with status full
// when the slot at the write pointer still has readers that have not taken its old word;
// a read is refused with status empty when that reader has caught up with the writer or
// names a reader that does not exist. Each pointer carries a lap bit beside its slot
// index, so a reader a full lap behind is told apart from one that is level. The words
// and the per-slot counts of readers still to read live in two synchronous RAMs; on
// acceptance of a request both RAMs are read at the slot, and in the execute state the
// block decides, writes back and loads the result register. No new request is taken
// until the execute state is done. The result register lets the next request in while
// a result still waits; a request only stalls in the execute state if the previous
// result has not been taken. After reset the block clears the count RAM, one slot a
// cycle, and accepts no request during that pass.
`default_nettype none
`include "assert_macros.svh"

module broadcast_ring_buffer_unit #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned READERS    = 4,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // Request stream.
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  // in_tdata, low bit up: reader_id [1:0], wdata [33:2], zero fill [39:34].
  input  wire logic [brb_pkg::IN_TDATA_W-1:0]       in_tdata,
  // in_tuser: cmd [0].
  input  wire logic                                 in_tuser,
  // Result stream.
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  // out_tdata, low bit up: rdata [31:0], slot [35:32], zero fill [39:36].
  output logic      [brb_pkg::OUT_TDATA_W-1:0]      out_tdata,
  // out_tuser: status [1:0].
  output logic      [brb_pkg::STATUS_W-1:0]         out_tuser
);

  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW   = $clog2(READERS + 1);
  localparam int unsigned RSEL = (READERS > 1) ? $clog2(READERS) : 1;

  // Control state.
  brb_pkg::brb_state_t state_r, state_nxt;
  logic [AW-1:0]       clr_idx_r, clr_idx_nxt;

  // Write pointer and the readers' pointers, each a slot index and a lap bit.
  logic [AW-1:0]       wp_idx_r, wp_idx_nxt;
  logic                wp_lap_r, wp_lap_nxt;
  logic [AW-1:0]       rp_idx_r [READERS];
  logic                rp_lap_r [READERS];

  // The request under work, captured at acceptance.
  logic                      cmd_r;
  logic [brb_pkg::RID_W-1:0] rid_r;
  logic [DATA_WIDTH-1:0]     wdata_r;
  logic [AW-1:0]             slot_r;
  logic                      rid_ok_r;
  logic [RSEL-1:0]           rsel_r;

  // Result register.
  logic                          out_valid_r;
  logic [brb_pkg::STATUS_W-1:0]  out_status_r, out_status_nxt;
  logic [brb_pkg::WORD_W-1:0]    out_rdata_r, out_rdata_nxt;
  logic [brb_pkg::SLOT_W-1:0]    out_slot_r, out_slot_nxt;

  // Decoded request fields at the input.
  logic                      in_cmd;
  logic [brb_pkg::RID_W-1:0] in_rid;
  logic [DATA_WIDTH-1:0]     in_wdata;
  logic                      in_rid_ok;
  logic [RSEL-1:0]           in_rsel;
  logic [AW-1:0]             in_slot;
  logic                      accept;

  // RAM ports.
  logic                  mem_re;
  logic                  store_we;
  logic [DATA_WIDTH-1:0] store_rd;
  logic                  cnt_we;
  logic [AW-1:0]         cnt_waddr;
  logic [CW-1:0]         cnt_wdata;
  logic [CW-1:0]         cnt_rd;

  // Decision in the execute state.
  logic          exec_done;
  logic          wr_ok;
  logic          rd_ok;
  logic          rd_pending;
  logic [AW-1:0] slot_inc;
  logic          slot_wrap;

  // ------------------------------------------------------------------
  // Input decode. A reader number at or above READERS is refused later
  // and reads slot zero, which keeps the pointer lookup inside the array.
  // ------------------------------------------------------------------
  assign in_cmd    = in_tuser;
  assign in_rid    = in_tdata[brb_pkg::RID_W-1:0];
  assign in_wdata  = DATA_WIDTH'(in_tdata[brb_pkg::RID_W +: brb_pkg::WORD_W]);
  assign in_rid_ok = (32'(in_rid) < READERS);
  assign in_rsel   = RSEL'(in_rid);

  always_comb begin
    if (in_cmd == brb_pkg::CMD_WRITE) begin
      in_slot = wp_idx_r;
    end else if (in_rid_ok) begin
      in_slot = rp_idx_r[in_rsel];
    end else begin
      in_slot = '0;
    end
  end

  assign accept = in_tvalid && in_tready;

  // ------------------------------------------------------------------
  // Memories: the data words and the per-slot count of readers that
  // still have to read the slot.
  // ------------------------------------------------------------------
  brb_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (slot_r),
    .wdata (wdata_r),
    .re    (mem_re),
    .raddr (in_slot),
    .rdata (store_rd)
  );

  brb_ram #(
    .WIDTH (CW),
    .DEPTH (DEPTH)
  ) u_count (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .re    (mem_re),
    .raddr (in_slot),
    .rdata (cnt_rd)
  );

  // ------------------------------------------------------------------
  // Decision. Only one request is in flight, so the count read at
  // acceptance always reflects the previous request's write-back.
  // ------------------------------------------------------------------
  assign slot_wrap  = (slot_r == AW'(DEPTH - 1));
  assign slot_inc   = slot_wrap ? '0 : slot_r + 1'b1;
  assign rd_pending = !((rp_idx_r[rsel_r] == wp_idx_r) && (rp_lap_r[rsel_r] == wp_lap_r));
  assign wr_ok      = (cmd_r == brb_pkg::CMD_WRITE) && (cnt_rd == '0);
  assign rd_ok      = (cmd_r == brb_pkg::CMD_READ) && rid_ok_r && rd_pending;
  assign exec_done  = (state_r == brb_pkg::ST_EXEC) && (!out_valid_r || out_tready);

  always_comb begin
    out_status_nxt = brb_pkg::STATUS_OK;
    out_rdata_nxt  = '0;
    out_slot_nxt   = brb_pkg::SLOT_W'(slot_r);
    if (cmd_r == brb_pkg::CMD_WRITE) begin
      if (!wr_ok) begin
        out_status_nxt = brb_pkg::STATUS_FULL;
      end
    end else if (rd_ok) begin
      out_rdata_nxt = brb_pkg::WORD_W'(store_rd);
    end else begin
      out_status_nxt = brb_pkg::STATUS_EMPTY;
    end
  end

  // ------------------------------------------------------------------
  // State machine: clearing pass after reset, then idle / execute.
  // ------------------------------------------------------------------
  always_comb begin
    state_nxt   = state_r;
    clr_idx_nxt = clr_idx_r;
    unique case (state_r)
      brb_pkg::ST_CLEAR: begin
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == AW'(DEPTH - 1)) begin
          state_nxt = brb_pkg::ST_IDLE;
        end
      end
      brb_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = brb_pkg::ST_EXEC;
        end
      end
      brb_pkg::ST_EXEC: begin
        if (exec_done) begin
          state_nxt = brb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = brb_pkg::ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    mem_re    = 1'b0;
    store_we  = 1'b0;
    cnt_we    = 1'b0;
    cnt_waddr = slot_r;
    cnt_wdata = '0;
    unique case (state_r)
      brb_pkg::ST_CLEAR: begin
        cnt_we    = 1'b1;
        cnt_waddr = clr_idx_r;
      end
      brb_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        mem_re    = in_tvalid;
      end
      brb_pkg::ST_EXEC: begin
        if (exec_done && wr_ok) begin
          store_we  = 1'b1;
          cnt_we    = 1'b1;
          cnt_wdata = CW'(READERS);
        end else if (exec_done && rd_ok && (cnt_rd != '0)) begin
          cnt_we    = 1'b1;
          cnt_wdata = cnt_rd - 1'b1;
        end
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  always_comb begin
    wp_idx_nxt = wp_idx_r;
    wp_lap_nxt = wp_lap_r;
    if (exec_done && wr_ok) begin
      wp_idx_nxt = slot_inc;
      wp_lap_nxt = wp_lap_r ^ slot_wrap;
    end
  end

  // ------------------------------------------------------------------
  // Registers.
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= brb_pkg::ST_CLEAR;
      clr_idx_r <= '0;
      wp_idx_r  <= '0;
      wp_lap_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_idx_r <= clr_idx_nxt;
      wp_idx_r  <= wp_idx_nxt;
      wp_lap_r  <= wp_lap_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < READERS; r++) begin
        rp_idx_r[r] <= '0;
        rp_lap_r[r] <= 1'b0;
      end
    end else if (exec_done && rd_ok) begin
      rp_idx_r[rsel_r] <= slot_inc;
      rp_lap_r[rsel_r] <= rp_lap_r[rsel_r] ^ slot_wrap;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r    <= in_cmd;
      rid_r    <= in_rid;
      wdata_r  <= in_wdata;
      slot_r   <= in_slot;
      rid_ok_r <= in_rid_ok;
      rsel_r   <= in_rsel;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (exec_done) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_done) begin
      out_status_r <= out_status_nxt;
      out_rdata_r  <= out_rdata_nxt;
      out_slot_r   <= out_slot_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {{(brb_pkg::OUT_TDATA_W - brb_pkg::SLOT_W - brb_pkg::WORD_W){1'b0}},
                       out_slot_r, out_rdata_r};

  // ------------------------------------------------------------------
  // Assertions.
  // ------------------------------------------------------------------
  `BRB_ASSERT_NEXT(a_accept_to_exec, clk, rst_n, accept, state_r == brb_pkg::ST_EXEC, "accepted request did not enter the execute cycle")
  `BRB_ASSERT_SAME(a_count_bound, clk, rst_n, cnt_we, 32'(cnt_wdata) <= READERS, "unread count written above the number of readers")
  `BRB_ASSERT_SAME(a_rdata_zero, clk, rst_n, out_tvalid && (out_tuser != brb_pkg::STATUS_OK), out_tdata[brb_pkg::WORD_W-1:0] == '0, "refused request carries nonzero read data")
  `BRB_ASSERT_SAME(a_bad_reader_slot, clk, rst_n, exec_done && (cmd_r == brb_pkg::CMD_READ) && !rid_ok_r, (slot_r == '0) && (32'(rid_r) >= READERS), "unknown reader did not fall back to slot zero")

endmodule

`default_nettype wire

### bench/broadcast_ring_buffer_unit_test.sv
// Self-checking testbench for the broadcast ring buffer: random requests against a ring mirror.
`timescale 1ns / 100ps

module broadcast_ring_buffer_unit_test;

  localparam int RING_DEPTH      = 16;
  localparam int NUM_READERS     = 4;
  localparam int RANDOM_REQUESTS = 1300;
  localparam int DRAIN_CYCLES    = 20;
  // The limit leaves ample margin for the slowest correct run, even with 53% idling.
  localparam int CYCLE_LIMIT     = 200000;

  typedef struct packed {
    logic [brb_pkg::STATUS_W-1:0] status;
    logic [brb_pkg::WORD_W-1:0]   rdata;
    logic [brb_pkg::SLOT_W-1:0]   slot;
  } ring_result_t;

  // Mirrors the ring state and holds the results still owed by the block.
  class ring_mirror;
    logic [brb_pkg::WORD_W-1:0] words [RING_DEPTH];
    logic [brb_pkg::SLOT_W-1:0] wr_slot;
    logic                       wr_lap;
    logic [brb_pkg::SLOT_W-1:0] rd_slot [NUM_READERS];
    logic                       rd_lap [NUM_READERS];
    int unsigned                unread [RING_DEPTH];
    ring_result_t               pending_results [$];
    int                         failures;

    function new();
      wr_slot = '0;
      wr_lap = 1'b0;
      foreach (rd_slot[r]) begin
        rd_slot[r] = '0;
        rd_lap[r] = 1'b0;
      end
      foreach (unread[s]) begin
        unread[s] = 0;
        words[s] = '0;
      end
      failures = 0;
    endfunction

    // Works out the result of one request and updates the mirrored pointers and counts.
    function ring_result_t predict_access(logic cmd, logic [brb_pkg::RID_W-1:0] rid,
                                          logic [brb_pkg::WORD_W-1:0] word);
      ring_result_t res;
      int r;
      res.status = brb_pkg::STATUS_OK;
      res.rdata = '0;
      res.slot = '0;
      if (cmd == brb_pkg::CMD_WRITE) begin
        res.slot = wr_slot;
        if (unread[wr_slot] != 0) begin
          res.status = brb_pkg::STATUS_FULL;
        end else begin
          words[wr_slot] = word;
          unread[wr_slot] = NUM_READERS;
          if (wr_slot == brb_pkg::SLOT_W'(RING_DEPTH - 1)) wr_lap = ~wr_lap;
          wr_slot = wr_slot + 1'b1;
        end
      end else if (int'(rid) >= NUM_READERS) begin
        res.status = brb_pkg::STATUS_EMPTY;
      end else begin
        r = int'(rid);
        res.slot = rd_slot[r];
        // Same index and same lap means the reader has caught up with the writer;
        // same index with differing laps means it is a full lap behind.
        if (rd_slot[r] == wr_slot && rd_lap[r] == wr_lap) begin
          res.status = brb_pkg::STATUS_EMPTY;
        end else begin
          res.rdata = words[rd_slot[r]];
          if (unread[rd_slot[r]] != 0) unread[rd_slot[r]]--;
          if (rd_slot[r] == brb_pkg::SLOT_W'(RING_DEPTH - 1)) rd_lap[r] = ~rd_lap[r];
          rd_slot[r] = rd_slot[r] + 1'b1;
        end
      end
      return res;
    endfunction

    function void note_request(logic cmd, logic [brb_pkg::RID_W-1:0] rid,
                               logic [brb_pkg::WORD_W-1:0] word);
      pending_results.push_back(predict_access(cmd, rid, word));
    endfunction

    function void check_result(ring_result_t got);
      ring_result_t exp;
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d, rdata 0x%08h, slot %0d",
               got.status, got.rdata, got.slot);
        failures++;
        return;
      end
      exp = pending_results.pop_front();
      if (got.status !== exp.status) begin
        $error("status mismatch: expected %0d, actual %0d", exp.status, got.status);
        failures++;
      end
      if (got.rdata !== exp.rdata) begin
        $error("rdata mismatch: expected 0x%08h, actual 0x%08h", exp.rdata, got.rdata);
        failures++;
      end
      if (got.slot !== exp.slot) begin
        $error("slot mismatch: expected %0d, actual %0d", exp.slot, got.slot);
        failures++;
      end
    endfunction
  endclass

  logic                            clk;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [brb_pkg::IN_TDATA_W-1:0]  in_tdata;
  logic                            in_tuser;
  logic                            out_tvalid;
  logic                            out_tready;
  logic [brb_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic [brb_pkg::STATUS_W-1:0]    out_tuser;

  int send_idle_pct;
  int recv_idle_pct;

  ring_mirror ring = new();

  broadcast_ring_buffer_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("tb: failure");
    $finish;
  end

  // Result side: ready is redrawn every falling edge, results are taken at rising edges.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      out_tready = ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  initial begin
    ring_result_t got;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        got.status = out_tuser;
        got.rdata = out_tdata[31:0];
        got.slot = out_tdata[35:32];
        ring.check_result(got);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic send_request(input logic cmd, input logic [brb_pkg::RID_W-1:0] rid,
                              input logic [brb_pkg::WORD_W-1:0] word);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser = cmd;
    in_tdata = {6'b0, word, rid};
    do @(posedge clk); while (!in_tready);
    ring.note_request(cmd, rid, word);
    @(negedge clk);
  endtask

  // Requests come in runs of 32 with a drifting write share, so the ring both
  // fills up (refused writes, lapped readers) and drains (refused reads).
  task automatic send_random_requests(input int count);
    int write_pct;
    logic cmd;
    write_pct = 50;
    for (int n = 0; n < count; n++) begin
      if (n % 32 == 0) begin
        case ($urandom_range(0, 2))
          0: write_pct = 15;
          1: write_pct = 50;
          default: write_pct = 85;
        endcase
      end
      cmd = ($urandom_range(0, 99) < write_pct) ? brb_pkg::CMD_WRITE : brb_pkg::CMD_READ;
      send_request(cmd, brb_pkg::RID_W'($urandom_range(0, NUM_READERS - 1)), $urandom());
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = brb_pkg::CMD_WRITE;
    send_idle_pct = 6;
    recv_idle_pct = 53;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part. A read of an empty ring is refused first.
    send_request(brb_pkg::CMD_READ, brb_pkg::RID_W'(0), 32'h0);
    // Fill every slot, starting with the all-zero and all-one words.
    for (int i = 0; i < RING_DEPTH; i++) begin
      send_request(brb_pkg::CMD_WRITE, brb_pkg::RID_W'(i),
                   (i == 0) ? 32'h0000_0000 : (i == 1) ? 32'hFFFF_FFFF : $urandom());
    end
    // Slot zero still has unread readers, so this write is refused.
    send_request(brb_pkg::CMD_WRITE, brb_pkg::RID_W'(0), 32'hA5A5_5A5A);
    // Every reader takes slot zero, which frees it for the writer's second lap.
    send_request(brb_pkg::CMD_READ, brb_pkg::RID_W'(1), 32'h0);
    send_request(brb_pkg::CMD_READ, brb_pkg::RID_W'(0), 32'h0);
    send_request(brb_pkg::CMD_READ, brb_pkg::RID_W'(2), 32'h0);
    send_request(brb_pkg::CMD_READ, brb_pkg::RID_W'(3), 32'h0);
    send_request(brb_pkg::CMD_WRITE, brb_pkg::RID_W'(3), 32'h5555_AAAA);
    // Readers now sit a full lap behind the writer at the same index.
    send_request(brb_pkg::CMD_READ, brb_pkg::RID_W'(2), 32'h0);
    send_request(brb_pkg::CMD_READ, brb_pkg::RID_W'(3), 32'h0);

    send_random_requests(RANDOM_REQUESTS / 3);
    send_idle_pct = 53;
    recv_idle_pct = 6;
    send_random_requests(RANDOM_REQUESTS / 3);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random_requests(RANDOM_REQUESTS - 2 * (RANDOM_REQUESTS / 3));
    in_tvalid = 1'b0;

    while (ring.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (ring.failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
